>>> design/pfrc_pkg.sv
// Shared types, constants and the control program of the PCM format and rate converter.
`timescale 1ns / 1ps

package pfrc_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int RATE_W         = 18;
  localparam int PHASE_W        = 20;
  localparam int CFG_IDX_W      = 3;
  localparam int STEP_W         = 3;
  localparam int MAX_REPEAT_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IN_SIXTEEN_BIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_STEREO       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SIXTEEN_BIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_STEREO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IN_RATE         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE        = 3'd5;

  localparam logic [RATE_W-1:0] RATE_RST = 18'd8000;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT     = 3'd0;
  localparam step_t STEP_RECODE   = 3'd1;
  localparam step_t STEP_ADD_RATE = 3'd2;
  localparam step_t STEP_TEST     = 3'd3;
  localparam step_t STEP_EMIT     = 3'd4;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_RECODE,
    OP_ADD_RATE,
    OP_TEST,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    J_GOTO,    // always go to target
    J_INPUT,   // go to target once an item is taken, else hold
    J_NO_POS,  // go to target if the phase is not positive, else fall through
    J_LAST     // go to target after the final result, else hold
  } jmp_t;

  typedef struct packed {
    op_t   op;
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic phase_pos;
    logic emit_done;
    logic emit_last;
  } stat_t;

  typedef struct packed {
    logic              in_sixteen_bit;
    logic              in_stereo;
    logic              out_sixteen_bit;
    logic              out_stereo;
    logic [RATE_W-1:0] in_rate;
    logic [RATE_W-1:0] out_rate;
  } cfg_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    case (s)
      STEP_WAIT:     w = '{op: OP_IDLE,     jmp: J_INPUT,  target: STEP_RECODE};
      STEP_RECODE:   w = '{op: OP_RECODE,   jmp: J_GOTO,   target: STEP_ADD_RATE};
      STEP_ADD_RATE: w = '{op: OP_ADD_RATE, jmp: J_GOTO,   target: STEP_TEST};
      STEP_TEST:     w = '{op: OP_TEST,     jmp: J_NO_POS, target: STEP_WAIT};
      STEP_EMIT:     w = '{op: OP_EMIT,     jmp: J_LAST,   target: STEP_WAIT};
      default:       w = '{op: OP_IDLE,     jmp: J_GOTO,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> design/pfrc_seq.sv
// Step counter and control store of the converter's microcoded sequencer.
`timescale 1ns / 1ps

module pfrc_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  pfrc_pkg::stat_t stat,
  output pfrc_pkg::ctrl_t ctrl
);

  pfrc_pkg::step_t step_r;
  pfrc_pkg::step_t step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pfrc_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctrl     = pfrc_pkg::ucode(step_r);
    step_nxt = step_r;
    case (ctrl.jmp)
      pfrc_pkg::J_GOTO: begin
        step_nxt = ctrl.target;
      end
      pfrc_pkg::J_INPUT: begin
        if (stat.in_fire) step_nxt = ctrl.target;
      end
      pfrc_pkg::J_NO_POS: begin
        step_nxt = stat.phase_pos ? pfrc_pkg::step_t'(step_r + 1'b1) : ctrl.target;
      end
      pfrc_pkg::J_LAST: begin
        if (stat.emit_done && stat.emit_last) step_nxt = ctrl.target;
      end
      default: begin
        step_nxt = pfrc_pkg::STEP_WAIT;
      end
    endcase
  end

endmodule

>>> design/pfrc_datapath.sv
// Frame recoding, phase accumulator, repeat counter and output register.
`timescale 1ns / 1ps

module pfrc_datapath #(
  parameter int MAX_REPEAT = pfrc_pkg::MAX_REPEAT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfrc_pkg::cfg_t                    cfg,
  input  pfrc_pkg::ctrl_t                   ctrl,
  output pfrc_pkg::stat_t                   stat,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [2*pfrc_pkg::SAMPLE_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [2*pfrc_pkg::SAMPLE_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  localparam int SW = pfrc_pkg::SAMPLE_W;
  localparam int PW = pfrc_pkg::PHASE_W;
  localparam int CW = $clog2(MAX_REPEAT + 1);

  logic [SW-1:0]        in_left_r, in_right_r;
  logic [SW-1:0]        ol_r, or_r;
  logic [SW-1:0]        ol_nxt, or_nxt;
  logic signed [PW-1:0] phase_r;
  logic [CW-1:0]        cnt_r;
  logic                 out_valid_r;
  logic [SW-1:0]        out_left_r, out_right_r;
  logic                 out_last_r;

  logic [SW-1:0]        l_w, r_w;
  logic [SW:0]          sum_w, sum_half_w, sum_q_w;
  logic [SW-1:0]        l_q_w, r_q_w;
  logic signed [PW-1:0] phase_add_w, phase_sub_w;
  logic                 sub_pos_w, more_w, emit_w, in_fire_w;
  logic [CW-1:0]        cnt_inc_w;

  assign in_tready = (ctrl.op == pfrc_pkg::OP_IDLE);
  assign in_fire_w = in_tvalid && in_tready;

  // An 8-bit sample sits in the low byte; moving it to the high byte scales it by 256.
  assign l_w   = cfg.in_sixteen_bit ? in_left_r : {in_left_r[7:0], 8'h00};
  assign r_w   = !cfg.in_stereo ? l_w :
                 (cfg.in_sixteen_bit ? in_right_r : {in_right_r[7:0], 8'h00});
  assign sum_w = {l_w[SW-1], l_w} + {r_w[SW-1], r_w};

  // Negative values get a bias of divisor minus one so the shift truncates toward zero.
  assign sum_half_w = sum_w + {{SW{1'b0}}, sum_w[SW]};
  assign sum_q_w    = sum_w + (sum_w[SW] ? (SW+1)'(511) : '0);
  assign l_q_w      = l_w + (l_w[SW-1] ? SW'(255) : '0);
  assign r_q_w      = r_w + (r_w[SW-1] ? SW'(255) : '0);

  always_comb begin
    case ({cfg.out_sixteen_bit, cfg.out_stereo})
      2'b11: begin
        ol_nxt = l_w;
        or_nxt = r_w;
      end
      2'b10: begin
        ol_nxt = sum_half_w[SW:1];
        or_nxt = '0;
      end
      2'b01: begin
        ol_nxt = {{8{l_q_w[SW-1]}}, l_q_w[SW-1:8]};
        or_nxt = {{8{r_q_w[SW-1]}}, r_q_w[SW-1:8]};
      end
      default: begin
        ol_nxt = {{8{sum_q_w[SW]}}, sum_q_w[SW:9]};
        or_nxt = '0;
      end
    endcase
  end

  assign phase_add_w = phase_r + $signed({{(PW-pfrc_pkg::RATE_W){1'b0}}, cfg.out_rate});
  assign phase_sub_w = phase_r - $signed({{(PW-pfrc_pkg::RATE_W){1'b0}}, cfg.in_rate});
  assign sub_pos_w   = !phase_sub_w[PW-1] && (phase_sub_w != '0);
  assign cnt_inc_w   = cnt_r + 1'b1;
  assign more_w      = sub_pos_w && (cnt_inc_w < CW'(MAX_REPEAT));
  assign emit_w      = (ctrl.op == pfrc_pkg::OP_EMIT) && (!out_valid_r || out_tready);

  assign stat.in_fire   = in_fire_w;
  assign stat.phase_pos = !phase_r[PW-1] && (phase_r != '0);
  assign stat.emit_done = emit_w;
  assign stat.emit_last = !more_w;

  always_ff @(posedge clk) begin
    if (in_fire_w) begin
      in_left_r  <= in_tdata[SW-1:0];
      in_right_r <= in_tdata[2*SW-1:SW];
    end
    if (ctrl.op == pfrc_pkg::OP_RECODE) begin
      ol_r <= ol_nxt;
      or_r <= or_nxt;
    end
    if (emit_w) begin
      out_left_r  <= ol_r;
      out_right_r <= or_r;
      out_last_r  <= !more_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.op == pfrc_pkg::OP_ADD_RATE) begin
        phase_r <= phase_add_w;
        cnt_r   <= '0;
      end else if (emit_w) begin
        // Past the repeat limit the leftover positive phase is dropped.
        phase_r <= (!more_w && sub_pos_w) ? '0 : phase_sub_w;
        cnt_r   <= more_w ? cnt_inc_w : '0;
      end
      if (emit_w) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_right_r, out_left_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_phase_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_w && !more_w) |=> (phase_r[PW-1] || phase_r == '0))
    else $error("phase left positive after the final result of an item");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CW'(MAX_REPEAT))
    else $error("repeat counter reached the repeat limit");

  a_cnt_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_w && !more_w) |=> (cnt_r == '0))
    else $error("repeat counter not cleared after the final result");
`endif

endmodule

>>> design/pcm_format_rate_converter.sv
// Top level of the PCM format and nearest-neighbor rate converter.
//
//  Channel  Dir  Handshake             Payload
//  in_      in   in_tvalid/in_tready   in_tdata  {in_right, in_left}
//  out_     out  out_tvalid/out_tready out_tdata {out_right, out_left}, out_tlast
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// An item causes n results (0 to MAX_REPEAT) and passes through the step program:
// wait, recode, add rate, test, then one emit step per result.
// Reset (synchronous, rst_n low) clears the phase to zero and loads the register defaults.
// An emit step holds while the output register is full and not being taken.
// Configuration writes are always taken; cfg_ready is held high.
`timescale 1ns / 1ps

module pcm_format_rate_converter #(
  parameter int MAX_REPEAT = pfrc_pkg::MAX_REPEAT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] in_left, [31:16] in_right
  input  logic [2*pfrc_pkg::SAMPLE_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] out_left, [31:16] out_right
  output logic [2*pfrc_pkg::SAMPLE_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfrc_pkg::RATE_W-1:0]       cfg_data
);

  pfrc_pkg::cfg_t  cfg_r;
  pfrc_pkg::ctrl_t ctrl;
  pfrc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_sixteen_bit  <= 1'b1;
      cfg_r.in_stereo       <= 1'b0;
      cfg_r.out_sixteen_bit <= 1'b1;
      cfg_r.out_stereo      <= 1'b0;
      cfg_r.in_rate         <= pfrc_pkg::RATE_RST;
      cfg_r.out_rate        <= pfrc_pkg::RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfrc_pkg::REG_IN_SIXTEEN_BIT:  cfg_r.in_sixteen_bit  <= cfg_data[0];
        pfrc_pkg::REG_IN_STEREO:       cfg_r.in_stereo       <= cfg_data[0];
        pfrc_pkg::REG_OUT_SIXTEEN_BIT: cfg_r.out_sixteen_bit <= cfg_data[0];
        pfrc_pkg::REG_OUT_STEREO:      cfg_r.out_stereo      <= cfg_data[0];
        pfrc_pkg::REG_IN_RATE:         cfg_r.in_rate         <= cfg_data;
        pfrc_pkg::REG_OUT_RATE:        cfg_r.out_rate        <= cfg_data;
        default: ;
      endcase
    end
  end

  pfrc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  pfrc_datapath #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the PCM format and rate converter: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import pfrc_pkg::*;

  localparam int MAX_REPEAT = MAX_REPEAT_DEF;
  // Cycles to let the block finish an item that causes no result before a register write.
  localparam int SETTLE     = MAX_REPEAT + 8;
  localparam int SEGMENTS   = 4;
  localparam int SEG_ITEMS  = 22;
  localparam int DIR_N      = 43;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } frame_t;

  // One directed row: a register write, or an item with optional typed-in samples.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [RATE_W-1:0]    val;
    logic [15:0]          l_raw;
    logic [15:0]          r_raw;
    logic                 typed;
    logic [15:0]          el;
    logic [15:0]          er;
  } row_t;

  localparam row_t DIRECTED [DIR_N] = '{
    // After reset: 16-bit mono in and out, equal rates, one result per item.
    '{1'b0, '0, 18'd0, 16'h7FFF, 16'h0000, 1'b1, 16'h7FFF, 16'h0000},
    '{1'b0, '0, 18'd0, 16'h8000, 16'h1234, 1'b1, 16'h8000, 16'h0000},
    '{1'b0, '0, 18'd0, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, 16'h0000},
    '{1'b1, REG_IN_STEREO, 18'd1, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_OUT_STEREO, 18'd1, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
    // Mono mix must truncate toward zero on both signs.
    '{1'b1, REG_OUT_STEREO, 18'd0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h0003, 16'hFFFE, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, '0, 18'd0, 16'hFFFD, 16'h0002, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, '0, 18'd0, 16'hFFFF, 16'hFFFE, 1'b1, 16'hFFFF, 16'h0000},
    '{1'b1, REG_OUT_SIXTEEN_BIT, 18'd0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_OUT_STEREO, 18'd1, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'hFF01, 16'h00FF, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, '0, 18'd0, 16'h8000, 16'h7FFF, 1'b1, 16'hFF80, 16'h007F},
    '{1'b1, REG_OUT_STEREO, 18'd0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'hFF00, 16'hFF01, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, '0, 18'd0, 16'h8000, 16'h8000, 1'b1, 16'hFF80, 16'h0000},
    '{1'b0, '0, 18'd0, 16'h7FFF, 16'h7FFF, 1'b1, 16'h007F, 16'h0000},
    // 8-bit input: only the low byte counts.
    '{1'b1, REG_IN_SIXTEEN_BIT, 18'd0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'hAB80, 16'h127F, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, '0, 18'd0, 16'h0080, 16'hFF80, 1'b1, 16'hFF80, 16'h0000},
    '{1'b1, REG_OUT_SIXTEEN_BIT, 18'd1, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_OUT_STEREO, 18'd1, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h5A7F, 16'hA581, 1'b1, 16'h7F00, 16'h8100},
    '{1'b1, REG_IN_STEREO, 18'd0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h00FF, 16'h7777, 1'b1, 16'hFF00, 16'hFF00},
    // Upsampling repeats frames.
    '{1'b1, REG_OUT_RATE, 18'd44100, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h1357, 16'h9BDF, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h2468, 16'hACE0, 1'b0, 16'h0, 16'h0},
    // Too many repeats: capped at MAX_REPEAT, phase clamped.
    '{1'b1, REG_IN_RATE, 18'd1, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_OUT_RATE, 18'd262143, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h0102, 16'h0304, 1'b1, 16'h0200, 16'h0200},
    // Zero input rate: the phase never falls.
    '{1'b1, REG_IN_RATE, 18'd0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h00C3, 16'h5555, 1'b1, 16'hC300, 16'hC300},
    // Zero output rate: nothing is ever emitted.
    '{1'b1, REG_OUT_RATE, 18'd0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_IN_RATE, 18'd262143, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h1111, 16'h2222, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h3333, 16'h4444, 1'b0, 16'h0, 16'h0},
    // Downsampling drops frames.
    '{1'b1, REG_OUT_RATE, 18'd8000, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_IN_RATE, 18'd44100, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h7E01, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h8F02, 16'hFFFF, 1'b0, 16'h0, 16'h0},
    '{1'b0, '0, 18'd0, 16'h90FE, 16'h1234, 1'b0, 16'h0, 16'h0}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [RATE_W-1:0]    cfg_data   = '0;

  // Predictor copy of the registers and the phase.
  bit                fmt_in16   = 1'b1;
  bit                fmt_in_st  = 1'b0;
  bit                fmt_out16  = 1'b1;
  bit                fmt_out_st = 1'b0;
  logic [RATE_W-1:0] rate_in    = RATE_RST;
  logic [RATE_W-1:0] rate_out   = RATE_RST;
  int                phase      = 0;

  frame_t frames_due [$];
  int     mismatch_count = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  pcm_format_rate_converter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int widen_sample(input logic [15:0] raw);
    logic signed [15:0] s16;
    logic signed [7:0]  s8;
    s16 = raw;
    s8  = raw[7:0];
    if (fmt_in16) return int'(s16);
    return int'(s8) * 256;
  endfunction

  // Recodes one frame, advances the phase and queues every repeat it causes.
  function automatic int resample_frame(input logic [15:0] l_raw, input logic [15:0] r_raw);
    int     l, r, ol, orr, n;
    frame_t f;
    l = widen_sample(l_raw);
    r = fmt_in_st ? widen_sample(r_raw) : l;
    if (fmt_out16) begin
      if (fmt_out_st) begin
        ol  = l;
        orr = r;
      end else begin
        ol  = (l + r) / 2;
        orr = 0;
      end
    end else begin
      if (fmt_out_st) begin
        ol  = l / 256;
        orr = r / 256;
      end else begin
        ol  = (l + r) / 512;
        orr = 0;
      end
    end
    n = 0;
    phase = phase + int'(rate_out);
    while (phase > 0 && n < MAX_REPEAT) begin
      f.left  = ol[15:0];
      f.right = orr[15:0];
      f.last  = 1'b0;
      frames_due.push_back(f);
      phase = phase - int'(rate_in);
      n++;
    end
    if (phase > 0) phase = 0;
    if (n > 0) frames_due[frames_due.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(9))
      0:       return 18'd8000;
      1:       return 18'd11025;
      2:       return 18'd22050;
      3:       return 18'd44100;
      4:       return 18'd48000;
      5:       return 18'd96000;
      6:       return 18'd192000;
      7:       return 18'd1;
      8:       return '1;
      default: return RATE_W'($urandom_range(262143, 1));
    endcase
  endfunction

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (frames_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IN_SIXTEEN_BIT:  fmt_in16   = val[0];
      REG_IN_STEREO:       fmt_in_st  = val[0];
      REG_OUT_SIXTEEN_BIT: fmt_out16  = val[0];
      REG_OUT_STEREO:      fmt_out_st = val[0];
      REG_IN_RATE:         rate_in    = val;
      REG_OUT_RATE:        rate_out   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one item; with drain set the sender first holds off until nothing is expected.
  task automatic send_frame(input logic [15:0] l_raw, input logic [15:0] r_raw, input bit typed,
                            input logic [15:0] el, input logic [15:0] er, input bit drain);
    int gap, n;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (drain || gap > 0) begin
      in_tvalid <= 1'b0;
      if (drain) begin
        do @(posedge clk); while (frames_due.size() != 0);
      end
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r_raw, l_raw};
    do @(posedge clk); while (!in_tready);
    n = resample_frame(l_raw, r_raw);
    if (typed) begin
      for (int i = frames_due.size() - n; i < frames_due.size(); i++) begin
        frames_due[i].left  = el;
        frames_due[i].right = er;
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frames_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected: left %h right %h last %b",
                   $realtime, out_tdata[15:0], out_tdata[31:16], out_tlast);
      end else begin
        want = frames_due.pop_front();
        if (out_tdata[15:0] !== want.left || out_tdata[31:16] !== want.right ||
            out_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected left %h right %h last %b, got left %h right %h last %b",
                     $realtime, want.left, want.right, want.last,
                     out_tdata[15:0], out_tdata[31:16], out_tlast);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_N; k++) begin
      if (DIRECTED[k].is_cfg) begin
        wait_idle();
        cfg_write(DIRECTED[k].idx, DIRECTED[k].val);
      end else begin
        send_frame(DIRECTED[k].l_raw, DIRECTED[k].r_raw, DIRECTED[k].typed,
                   DIRECTED[k].el, DIRECTED[k].er, 1'b0);
      end
    end

    // Four backpressure modes, each with several random register settings.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_idle();
        cfg_write(REG_IN_SIXTEEN_BIT, RATE_W'($urandom()));
        cfg_write(REG_IN_STEREO, RATE_W'($urandom()));
        cfg_write(REG_OUT_SIXTEEN_BIT, RATE_W'($urandom()));
        cfg_write(REG_OUT_STEREO, RATE_W'($urandom()));
        cfg_write(REG_IN_RATE, ($urandom_range(19) == 0) ? '0 : pick_rate());
        cfg_write(REG_OUT_RATE, pick_rate());
        for (int item = 0; item < SEG_ITEMS; item++) begin
          send_frame(16'($urandom()), 16'($urandom()), 1'b0, 16'h0, 16'h0,
                     mode == 1 && item == 12);
        end
      end
    end

    wait_idle();
    if (frames_due.size() != 0)
      $display("%0d expected results never arrived", frames_due.size());
    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("** pcm_format_rate_converter: PASSED **");
    end else begin
      $display("** pcm_format_rate_converter: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** pcm_format_rate_converter: FAILED **");
    $finish;
  end

endmodule
